// File: sv/ptab_pkg.sv
// Package for the palette texel alpha blend stage: payload structs, constants,
// configuration register codes and the channel helper functions.
// No dependencies.
package ptab_pkg;

  localparam int SCREEN_W    = 320;
  localparam int SCREEN_H    = 240;
  localparam int PAL_ENTRIES = 256;
  localparam int PAL_IDX_W   = $clog2(PAL_ENTRIES);
  localparam int COORD_W     = 9;
  localparam int ADDR_W      = 17;
  localparam int PIX_W       = 32;
  localparam int CH_W        = 8;
  localparam int SHIFT_W     = 5;
  localparam int CFG_IDX_W   = 3;
  localparam int NUM_CH      = 3;

  localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'd255;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_DRAW = 1'b1
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RED_MASK    = 3'd0,
    REG_GREEN_MASK  = 3'd1,
    REG_BLUE_MASK   = 3'd2,
    REG_RED_SHIFT   = 3'd3,
    REG_GREEN_SHIFT = 3'd4,
    REG_BLUE_SHIFT  = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic               func;
    logic [7:0]         pal_index;
    logic [PIX_W-1:0]   pal_colour;
    logic               pal_transparent;
    logic [COORD_W-1:0] x_pos;
    logic [COORD_W-1:0] y_pos;
    logic [7:0]         texel;
    logic [7:0]         pal_base;
    logic [CH_W-1:0]    alpha;
    logic [PIX_W-1:0]   dest_pixel;
    logic               last_texel;
  } texel_item_t;

  typedef struct packed {
    logic              write_en;
    logic [ADDR_W-1:0] write_addr;
    logic [PIX_W-1:0]  write_pixel;
    logic              last_write;
  } pixel_item_t;

  // Palette entry as stored: transparency flag above the colour.
  typedef struct packed {
    logic             transparent;
    logic [PIX_W-1:0] colour;
  } pal_entry_t;

  // Masked channel brought down to bit zero and cut to eight bits.
  function automatic logic [CH_W-1:0] chan_get(input logic [PIX_W-1:0] pix,
                                               input logic [PIX_W-1:0] mask,
                                               input logic [SHIFT_W-1:0] sh);
    logic [PIX_W-1:0] t;
    t = (pix & mask) >> sh;
    return t[CH_W-1:0];
  endfunction

  function automatic logic [PIX_W-1:0] chan_put(input logic [CH_W-1:0] m,
                                                input logic [PIX_W-1:0] mask,
                                                input logic [SHIFT_W-1:0] sh);
    return ({{(PIX_W-CH_W){1'b0}}, m} << sh) & mask;
  endfunction

  // Exact s/255 for s below 65280: (s + 1 + (s >> 8)) >> 8.
  function automatic logic [CH_W-1:0] div255(input logic [15:0] s);
    logic [16:0] t;
    t = {1'b0, s} + 17'd1 + {9'd0, s[15:8]};
    return t[15:8];
  endfunction

endpackage

// File: sv/ptab_if.sv
// Valid/ready channel interfaces for texel input and pixel output.
// Depends on ptab_pkg for the payload structs.
interface ptab_texel_if import ptab_pkg::*; ();
  logic        valid;
  logic        ready;
  texel_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ptab_pixel_if import ptab_pkg::*; ();
  logic        valid;
  logic        ready;
  pixel_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: sv/ptab_palette.sv
// Palette store: 256 entries of colour plus transparency, one write port and
// one registered read port. Depends on ptab_pkg.
module ptab_palette import ptab_pkg::*; (
  input  logic                 clk,
  input  logic                 we,
  input  logic [PAL_IDX_W-1:0] waddr,
  input  pal_entry_t           wdata,
  input  logic                 re,
  input  logic [PAL_IDX_W-1:0] raddr,
  output pal_entry_t           rdata
);

  pal_entry_t mem [PAL_ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/palette_texel_alpha_blend.sv
// Top level of the palette texel alpha blend stage: palette load, lookup,
// clipping and three-channel blend. Depends on ptab_pkg, ptab_if, ptab_palette.
//
//   channel    dir   handshake        transaction
//   texel_in   in    valid/ready      one load or draw item
//   pixel_out  out   valid/ready      one framebuffer write per draw item
//   cfg        in    cfg_we           one register write, no stall
//
// One item per clock while pixel_out is not stalled. A draw result is registered in the
// palette read, the channel products, then after the sum and divide by 255 in the output
// register.
// Each stage moves on when the stage after it is empty or moving, so bubbles
// close up under an output stall. Loads finish in the acceptance cycle.
// Synchronous reset clears the stage valids and loads the default masks and shifts;
// the palette and the data registers hold no reset value.
module palette_texel_alpha_blend import ptab_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PIX_W-1:0]     cfg_data,
  ptab_texel_if.sink           texel_in,
  ptab_pixel_if.source         pixel_out
);

  logic [PIX_W-1:0]   mask  [NUM_CH];
  logic [SHIFT_W-1:0] shift [NUM_CH];

  always_ff @(posedge clk) begin
    if (rst) begin
      mask[0]  <= 32'h00ff_0000;
      mask[1]  <= 32'h0000_ff00;
      mask[2]  <= 32'h0000_00ff;
      shift[0] <= 5'd16;
      shift[1] <= 5'd8;
      shift[2] <= 5'd0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_RED_MASK:    mask[0]  <= cfg_data;
        REG_GREEN_MASK:  mask[1]  <= cfg_data;
        REG_BLUE_MASK:   mask[2]  <= cfg_data;
        REG_RED_SHIFT:   shift[0] <= cfg_data[SHIFT_W-1:0];
        REG_GREEN_SHIFT: shift[1] <= cfg_data[SHIFT_W-1:0];
        REG_BLUE_SHIFT:  shift[2] <= cfg_data[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage handshakes.
  logic v1, v2, v3;
  logic ready1, ready2, ready3;
  logic accept, load, draw;

  assign ready3 = !v3 || pixel_out.ready;
  assign ready2 = !v2 || ready3;
  assign ready1 = !v1 || ready2;
  assign texel_in.ready = ready1;
  assign accept = texel_in.valid && ready1;
  assign load = accept && (func_t'(texel_in.data.func) == FUNC_LOAD);
  assign draw = accept && (func_t'(texel_in.data.func) == FUNC_DRAW);

  // Palette lookup.
  logic [PAL_IDX_W-1:0] rd_idx;
  pal_entry_t           wr_entry;
  pal_entry_t           rd_entry;

  assign rd_idx = PAL_IDX_W'(texel_in.data.texel + texel_in.data.pal_base);
  assign wr_entry = '{transparent: texel_in.data.pal_transparent,
                      colour: texel_in.data.pal_colour};

  ptab_palette u_palette (
    .clk   (clk),
    .we    (load),
    .waddr (texel_in.data.pal_index[PAL_IDX_W-1:0]),
    .wdata (wr_entry),
    .re    (draw),
    .raddr (rd_idx),
    .rdata (rd_entry)
  );

  // Stage 1: draw item fields beside the palette read data.
  logic [COORD_W-1:0] x1, y1;
  logic [CH_W-1:0]    alpha1;
  logic [PIX_W-1:0]   dest1;
  logic               last1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ready1) begin
      v1 <= draw;
    end
  end

  always_ff @(posedge clk) begin
    if (draw) begin
      x1     <= texel_in.data.x_pos;
      y1     <= texel_in.data.y_pos;
      alpha1 <= texel_in.data.alpha;
      dest1  <= texel_in.data.dest_pixel;
      last1  <= texel_in.data.last_texel;
    end
  end

  // Stage 2: clip, address and channel products.
  logic              en1;
  logic [ADDR_W-1:0] addr1;
  logic [CH_W-1:0]   inv_alpha1;

  assign en1 = (x1 < COORD_W'(SCREEN_W)) && (y1 < COORD_W'(SCREEN_H))
               && !rd_entry.transparent;
  assign addr1 = ADDR_W'(x1) + ADDR_W'(SCREEN_W) * ADDR_W'(y1);
  assign inv_alpha1 = ALPHA_OPAQUE - alpha1;

  logic              en2, opaque2, last2;
  logic [ADDR_W-1:0] addr2;
  logic [PIX_W-1:0]  colour2;
  logic [15:0]       p_old [NUM_CH];
  logic [15:0]       p_new [NUM_CH];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ready2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2 && v1) begin
      en2     <= en1;
      opaque2 <= (alpha1 == ALPHA_OPAQUE);
      last2   <= last1;
      addr2   <= addr1;
      colour2 <= rd_entry.colour;
      for (int c = 0; c < NUM_CH; c++) begin
        p_old[c] <= 16'(inv_alpha1) * 16'(chan_get(dest1, mask[c], shift[c]));
        p_new[c] <= 16'(alpha1) * 16'(chan_get(rd_entry.colour, mask[c], shift[c]));
      end
    end
  end

  // Stage 3: sum, divide by 255, reassemble and register the result.
  logic [PIX_W-1:0] blend2;
  pixel_item_t      result2;

  always_comb begin
    blend2 = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      blend2 = blend2 | chan_put(div255(p_old[c] + p_new[c]), mask[c], shift[c]);
    end
    result2.write_en    = en2;
    result2.write_addr  = en2 ? addr2 : '0;
    result2.write_pixel = !en2 ? '0 : (opaque2 ? colour2 : blend2);
    result2.last_write  = last2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (ready3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ready3 && v2) begin
      pixel_out.data <= result2;
    end
  end

  assign pixel_out.valid = v3;

endmodule
